[rtl/rcbi_pkg.sv]
// Shared types, register addresses and time encoding for the RTC CMOS bus interface.
package rcbi_pkg;

  localparam int RAM_BYTES_DEF     = 64;
  localparam int UPDATE_PERIOD_DEF = 100;

  typedef enum logic [2:0] {
    KIND_ADDR_EN  = 3'd0,
    KIND_LATCH    = 3'd1,
    KIND_BUS_RD   = 3'd2,
    KIND_DIR_ADDR = 3'd3,
    KIND_DIR_WR   = 3'd4,
    KIND_DIR_RD   = 3'd5,
    KIND_RESET    = 3'd6
  } kind_e;

  localparam logic [5:0] ADDR_SEC   = 6'h00;
  localparam logic [5:0] ADDR_MIN   = 6'h02;
  localparam logic [5:0] ADDR_HOUR  = 6'h04;
  localparam logic [5:0] ADDR_WDAY  = 6'h06;
  localparam logic [5:0] ADDR_DAY   = 6'h07;
  localparam logic [5:0] ADDR_MONTH = 6'h08;
  localparam logic [5:0] ADDR_YEAR  = 6'h09;
  localparam logic [5:0] REG_A      = 6'h0a;
  localparam logic [5:0] REG_B      = 6'h0b;
  localparam logic [5:0] REG_C      = 6'h0c;
  localparam logic [5:0] BOOT_BYTE  = 6'h1e;

  localparam logic [7:0] BOOT_BIT   = 8'h10;
  localparam logic [7:0] REG_B_KEEP = 8'h87;
  localparam logic [7:0] BUS_IDLE   = 8'hff;

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [2:0] weekday;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } now_t;

  typedef struct packed {
    logic       bus_rd;
    logic       dir_rd;
    logic       load_latch;
    logic       bus_ok;
    logic [5:0] addr;
    logic [7:0] reg_b;
    now_t       now;
    logic [7:0] ram_data;
    logic       ram_hit;
  } stage_t;

  function automatic logic is_time_reg(input logic [5:0] a);
    return ((a <= ADDR_WDAY) && !a[0]) || ((a >= ADDR_DAY) && (a <= ADDR_YEAR));
  endfunction

  function automatic logic [6:0] time_value(input logic [5:0] a, input now_t n);
    logic [6:0] v;
    case (a)
      ADDR_SEC:   v = {1'b0, n.seconds};
      ADDR_MIN:   v = {1'b0, n.minutes};
      ADDR_HOUR:  v = {2'b0, n.hours};
      ADDR_WDAY:  v = {4'b0, n.weekday};
      ADDR_DAY:   v = {2'b0, n.day};
      ADDR_MONTH: v = {3'b0, n.month};
      default:    v = (n.year >= 7'd100) ? n.year - 7'd100 : n.year;
    endcase
    return v;
  endfunction

  // tens by reciprocal multiply, exact for every 7-bit input
  function automatic logic [7:0] encode_time(input logic [6:0] v, input logic binary);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 15'(v) * 15'd205;
    tens  = prod[14:11];
    units = v - 7'(7'(tens) * 7'd10);
    return binary ? {1'b0, v} : {tens, units[3:0]};
  endfunction

endpackage

[rtl/rcbi_in_if.sv]
// Input channel: one host bus event with the current time.
interface rcbi_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] value;
  logic [7:0] bus_data;
  logic [5:0] now_seconds;
  logic [5:0] now_minutes;
  logic [4:0] now_hours;
  logic [2:0] now_weekday;
  logic [4:0] now_day;
  logic [3:0] now_month;
  logic [6:0] now_year;

  modport source (
    output valid, kind, value, bus_data, now_seconds, now_minutes, now_hours,
           now_weekday, now_day, now_month, now_year,
    input  ready
  );
  modport sink (
    input  valid, kind, value, bus_data, now_seconds, now_minutes, now_hours,
           now_weekday, now_day, now_month, now_year,
    output ready
  );
endinterface

[rtl/rcbi_out_if.sv]
// Output channel: one read byte.
interface rcbi_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

[rtl/rcbi_front.sv]
// Accept stage: bus control registers, CMOS RAM with registered read, register B shadow.
module rcbi_front #(
  parameter int RAM_BYTES = rcbi_pkg::RAM_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  rcbi_in_if.sink          in_i,
  input  logic             s1_ready_i,
  output logic             s1_valid_o,
  output rcbi_pkg::stage_t stage_o
);

  localparam int AW = $clog2(RAM_BYTES);

  logic [7:0]           mem_q [RAM_BYTES];
  logic [RAM_BYTES-1:0] vld_q;
  logic [5:0]           addr_q;
  logic                 ce_q;
  logic                 rnw_q;
  logic                 stb_q;
  logic [7:0]           breg_q;
  logic                 s1_valid_q;
  rcbi_pkg::stage_t     stage_q;

  logic                 accept;
  rcbi_pkg::kind_e      kind;
  logic                 lvl;
  logic                 rnw_new;
  logic                 toggle;
  logic                 wr_en;
  logic                 wr_ok;
  logic [5:0]           wr_addr;
  logic [7:0]           wr_data;
  logic [AW-1:0]        wr_idx;
  logic [AW-1:0]        rd_idx;
  logic                 rd_in_rng;

  assign in_i.ready = !s1_valid_q || s1_ready_i;
  assign accept     = in_i.valid && in_i.ready;
  assign kind       = rcbi_pkg::kind_e'(in_i.kind);
  assign lvl        = in_i.value[2];
  assign rnw_new    = in_i.value[1];
  assign toggle     = (lvl != stb_q) && ce_q;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr_q;
    wr_data = in_i.bus_data;
    case (kind)
      rcbi_pkg::KIND_LATCH: begin
        wr_en = toggle && !rnw_new && !lvl;
      end
      rcbi_pkg::KIND_DIR_WR: begin
        wr_en   = 1'b1;
        wr_data = in_i.value;
      end
      rcbi_pkg::KIND_RESET: begin
        wr_en   = 1'b1;
        wr_addr = rcbi_pkg::REG_C;
        wr_data = 8'h00;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign wr_ok     = accept && wr_en && (int'(wr_addr) < RAM_BYTES);
  assign wr_idx    = AW'(wr_addr);
  assign rd_idx    = AW'(addr_q);
  assign rd_in_rng = int'(addr_q) < RAM_BYTES;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q     <= '0;
      ce_q       <= 1'b0;
      rnw_q      <= 1'b0;
      stb_q      <= 1'b0;
      breg_q     <= '0;
      vld_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_valid_q <= accept;
      end
      if (wr_ok) begin
        vld_q[wr_idx] <= 1'b1;
      end
      if (accept) begin
        case (kind)
          rcbi_pkg::KIND_ADDR_EN: begin
            if (in_i.value[7]) begin
              addr_q <= in_i.bus_data[5:0];
            end
            ce_q <= in_i.value[6];
          end
          rcbi_pkg::KIND_LATCH: begin
            rnw_q <= rnw_new;
            stb_q <= lvl;
          end
          rcbi_pkg::KIND_DIR_ADDR: begin
            addr_q <= in_i.value[5:0];
          end
          default: begin
          end
        endcase
      end
      if (accept && kind == rcbi_pkg::KIND_RESET) begin
        breg_q <= breg_q & rcbi_pkg::REG_B_KEEP;
      end else if (wr_ok && wr_addr == rcbi_pkg::REG_B) begin
        breg_q <= wr_data;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_idx] <= wr_data;
    end
    if (accept) begin
      stage_q.bus_rd        <= kind == rcbi_pkg::KIND_BUS_RD;
      stage_q.dir_rd        <= kind == rcbi_pkg::KIND_DIR_RD;
      stage_q.load_latch    <= (kind == rcbi_pkg::KIND_LATCH) && toggle && rnw_new && lvl;
      stage_q.bus_ok        <= ce_q && stb_q && rnw_q;
      stage_q.addr          <= addr_q;
      stage_q.reg_b         <= breg_q;
      stage_q.now.seconds   <= in_i.now_seconds;
      stage_q.now.minutes   <= in_i.now_minutes;
      stage_q.now.hours     <= in_i.now_hours;
      stage_q.now.weekday   <= in_i.now_weekday;
      stage_q.now.day       <= in_i.now_day;
      stage_q.now.month     <= in_i.now_month;
      stage_q.now.year      <= in_i.now_year;
      stage_q.ram_data      <= mem_q[rd_idx];
      stage_q.ram_hit       <= rd_in_rng && vld_q[rd_idx];
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign stage_o    = stage_q;

endmodule

[rtl/rcbi_back.sv]
// Result stage: read composition, output latch, update counter, result register.
module rcbi_back #(
  parameter int UPDATE_PERIOD = rcbi_pkg::UPDATE_PERIOD_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             s1_valid_i,
  input  rcbi_pkg::stage_t stage_i,
  output logic             s1_ready_o,
  rcbi_out_if.source       out_o
);

  logic       autoboot_q;
  logic [7:0] latch_q;
  logic [6:0] cnt_q;
  logic       out_valid_q;
  logic [7:0] out_data_q;

  logic [7:0] ram_v;
  logic       is_t;
  logic [7:0] t_byte;
  logic [7:0] strobed;
  logic [7:0] direct;
  logic [6:0] cnt_inc;
  logic       period_hit;
  logic       reg_a_rd;
  logic       has_res;
  logic       adv;
  logic [7:0] res;

  always_comb begin
    ram_v = stage_i.ram_hit ? stage_i.ram_data : 8'h00;
    if (stage_i.addr == rcbi_pkg::REG_B) begin
      ram_v = stage_i.reg_b;
    end
  end

  assign is_t   = rcbi_pkg::is_time_reg(stage_i.addr);
  assign t_byte = rcbi_pkg::encode_time(rcbi_pkg::time_value(stage_i.addr, stage_i.now),
                                        stage_i.reg_b[2]);

  assign strobed = is_t ? t_byte :
                   (ram_v | (((stage_i.addr == rcbi_pkg::BOOT_BYTE) && autoboot_q) ?
                             rcbi_pkg::BOOT_BIT : 8'h00));

  assign cnt_inc    = cnt_q + 7'd1;
  assign period_hit = cnt_inc == 7'(UPDATE_PERIOD);
  assign reg_a_rd   = stage_i.dir_rd && !is_t && (stage_i.addr == rcbi_pkg::REG_A);

  assign direct = is_t ? t_byte :
                  ((stage_i.addr == rcbi_pkg::REG_A) ? {period_hit, ram_v[6:0]} : ram_v);

  assign has_res    = stage_i.bus_rd || stage_i.dir_rd;
  assign s1_ready_o = !has_res || !out_valid_q || out_o.ready;
  assign adv        = s1_valid_i && s1_ready_o;
  assign res        = stage_i.bus_rd ? (stage_i.bus_ok ? latch_q : rcbi_pkg::BUS_IDLE) : direct;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      autoboot_q  <= 1'b0;
      latch_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        autoboot_q <= cfg_wdata_i;
      end
      if (adv && stage_i.load_latch) begin
        latch_q <= strobed;
      end
      if (adv && reg_a_rd) begin
        cnt_q <= period_hit ? 7'd0 : cnt_inc;
      end
      if (adv && has_res) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;

endmodule

[rtl/rtc_cmos_bus_interface.sv]
// Top level of the RTC CMOS bus interface.
// Takes one bus event per clock; reads (bus read, direct data read) return their byte through
// the CMOS RAM's registered read port followed by the result register. The RAM has one
// write and one read port and a valid flop per byte, so reset takes effect at once with no
// clearing pass. Output back-pressure stalls the input only once a read waits behind an
// unaccepted result.
module rtc_cmos_bus_interface #(
  parameter int RAM_BYTES     = rcbi_pkg::RAM_BYTES_DEF,
  parameter int UPDATE_PERIOD = rcbi_pkg::UPDATE_PERIOD_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  rcbi_in_if.sink    in_i,
  rcbi_out_if.source out_o
);

  logic             s1_valid;
  logic             s1_ready;
  rcbi_pkg::stage_t stage;

  rcbi_front #(
    .RAM_BYTES (RAM_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .s1_ready_i (s1_ready),
    .s1_valid_o (s1_valid),
    .stage_o    (stage)
  );

  rcbi_back #(
    .UPDATE_PERIOD (UPDATE_PERIOD)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s1_valid_i  (s1_valid),
    .stage_i     (stage),
    .s1_ready_o  (s1_ready),
    .out_o       (out_o)
  );

endmodule

[rtl/rcbi_checker.sv]
// Port-level assertions for the RTC CMOS bus interface, bound to the top level.
module rcbi_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [2:0] in_kind_i,
  input logic [7:0] in_value_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_data_i
);

  logic in_beat;
  logic rd_beat;

  assign in_beat = in_valid_i && in_ready_i;
  assign rd_beat = in_beat && (in_kind_i == rcbi_pkg::KIND_BUS_RD ||
                               in_kind_i == rcbi_pkg::KIND_DIR_RD);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result beat dropped or changed while stalled");

  a_rise_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(rd_beat, 2))
    else $error("result appeared without a read beat two cycles before");

  a_disabled_bus: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && in_kind_i == rcbi_pkg::KIND_ADDR_EN && !in_value_i[6]) ##1
    (in_beat && in_kind_i == rcbi_pkg::KIND_BUS_RD && !out_valid_i)
    |=> ##1 (out_valid_i && out_data_i == rcbi_pkg::BUS_IDLE))
    else $error("bus read with chip disabled did not return idle byte");

endmodule

bind rtc_cmos_bus_interface rcbi_checker u_rcbi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_kind_i   (in_i.kind),
  .in_value_i  (in_i.value),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.read_data)
);
